/* design/eva_pkg.sv */
package eva_pkg;

    localparam int CNT_W      = 32;
    localparam int TIME_W     = 32;
    localparam int VEL_W      = 32;
    localparam int DPT_W      = 16;
    localparam int SCALE      = 1000;
    localparam int SCALE_W    = 10;
    localparam int K_W        = DPT_W + SCALE_W;
    localparam int PROD_W     = CNT_W + K_W;
    localparam int DATA_IN_W  = CNT_W + TIME_W;

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DPT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_TICK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ENC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MOTOR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_DIV_VEL,
        ST_UPD,
        ST_AVG_GO,
        ST_DIV_AVG,
        ST_RESULT
    } eva_state_t;

    typedef struct packed {
        logic start;
        logic short_run;
    } eva_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eva_div_stat_t;

endpackage

/* design/eva_ram.sv */
module eva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/eva_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// A short run takes only the low SHORT_W bits of the dividend.
module eva_divider #(
    parameter int DVD_W   = 58,
    parameter int DVS_W   = 32,
    parameter int SHORT_W = 35
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  eva_pkg::eva_div_req_t req,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [DVS_W-1:0]      divisor,
    output eva_pkg::eva_div_stat_t stat,
    output logic [DVD_W-1:0]      quotient
);

    localparam int SHIFT = DVD_W - SHORT_W;
    localparam int CW    = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= req.short_run ? CW'(SHORT_W) : CW'(DVD_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.short_run ? (dividend << SHIFT) : dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
            rem_reg <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

/* design/encoder_velocity_averager.sv */
// Encoder velocity averager.
// Input stream: one transfer per sample, tdata = {time_ms, encoder_count}.
// Output stream: one transfer per sample, tdata = average_velocity (Q16.16
// in/s), tuser = updated. Registers are written through cfg_wen/cfg_index/
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this.
// A sample with zero elapsed time goes from ST_CALC straight to ST_RESULT.
// Otherwise the velocity quotient goes through the serial divider (a full
// 58-bit run) and the history mean goes through the same divider (a short
// run of 32 + clog2(HISTORY_DEPTH) bits) before ST_RESULT.
// One sample is in flight at a time; s_axis_tready is high only when idle,
// so a sample is taken only once the last result is loaded for output.
// The result sits in an output register; if the receiver stalls, the next
// sample is still taken and computed, and its result waits until the
// output register is free.
// Reset clears the previous count/time, the running sum, the last mean and
// the history valid bits, so the history reads as all zero at once.
module encoder_velocity_averager #(
    parameter int HISTORY_DEPTH = eva_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] encoder_count, [63:32] time_ms
    input  logic [eva_pkg::DATA_IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] average_velocity
    output logic [eva_pkg::VEL_W-1:0]      m_axis_tdata,
    // [0] updated
    output logic                           m_axis_tuser,
    input  logic                           cfg_wen,
    input  logic [eva_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eva_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W  = eva_pkg::VEL_W + $clog2(HISTORY_DEPTH);
    localparam int PW     = eva_pkg::PROD_W;
    localparam int VW     = eva_pkg::VEL_W;
    localparam int CW     = eva_pkg::CNT_W;
    localparam int TW     = eva_pkg::TIME_W;
    localparam int KW     = eva_pkg::K_W;

    eva_pkg::eva_state_t state_reg, state_next;

    logic [eva_pkg::DPT_W-1:0] dpt_reg;
    logic                      rev_enc_reg;
    logic                      rev_mot_reg;

    logic [CW-1:0]            cnt_reg;
    logic [TW-1:0]            time_reg;
    logic [CW-1:0]            prev_cnt_reg;
    logic [TW-1:0]            prev_time_reg;
    logic [CW-1:0]            tmag_reg;
    logic                     vneg_reg;
    logic [TW-1:0]            dt_reg;
    logic [KW-1:0]            k_reg;
    logic [VW-1:0]            v_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     avg_neg_reg;
    logic [VW-1:0]            last_avg_reg;
    logic                     upd_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic [HISTORY_DEPTH-1:0] valid_reg;

    logic                     out_valid_reg;
    logic [VW-1:0]            out_data_reg;
    logic                     out_user_reg;

    logic                     in_xfer;
    logic [CW-1:0]            in_count;
    logic [CW-1:0]            ticks;
    logic [TW-1:0]            dt;
    logic                     dt_zero;
    logic [PW-1:0]            vel_dividend;
    logic [PW-1:0]            qmag;
    logic                     sat_pos;
    logic                     sat_neg;
    logic [VW-1:0]            v_sat;
    logic [VW-1:0]            old_v;
    logic [VW-1:0]            ram_rdata;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         sum_mag;
    logic [VW-1:0]            avg_q;
    logic                     out_load;
    logic [PW-1:0]            div_quotient_w;

    eva_pkg::eva_div_req_t    div_req;
    eva_pkg::eva_div_stat_t   div_stat;
    logic [PW-1:0]            div_dividend;
    logic [VW-1:0]            div_divisor;

    assign s_axis_tready = (state_reg == eva_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_count = s_axis_tdata[CW-1:0];
        if (rev_enc_reg ^ rev_mot_reg)
        begin
            in_count = CW'(0) - s_axis_tdata[CW-1:0];
        end
        ticks   = cnt_reg - prev_cnt_reg;
        dt      = time_reg - prev_time_reg;
        dt_zero = (dt == '0);

        vel_dividend = PW'(tmag_reg) * PW'(k_reg);

        qmag    = div_quotient_w;
        sat_pos = !vneg_reg && (qmag[PW-1:VW-1] != '0);
        sat_neg = vneg_reg && ((qmag[PW-1:VW] != '0) ||
                               (qmag[VW-1] && (qmag[VW-2:0] != '0)));
        if (sat_pos)
        begin
            v_sat = {1'b0, {(VW-1){1'b1}}};
        end
        else if (sat_neg)
        begin
            v_sat = {1'b1, {(VW-1){1'b0}}};
        end
        else if (vneg_reg)
        begin
            v_sat = VW'(0) - qmag[VW-1:0];
        end
        else
        begin
            v_sat = qmag[VW-1:0];
        end

        old_v    = valid_reg[slot_reg] ? ram_rdata : '0;
        sum_next = sum_reg + SUM_W'($signed(v_reg)) - SUM_W'($signed(old_v));
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(0) - sum_reg : sum_reg;
        avg_q    = avg_neg_reg ? VW'(0) - qmag[VW-1:0] : qmag[VW-1:0];

        out_load = (state_reg == eva_pkg::ST_RESULT) && (!out_valid_reg || m_axis_tready);
    end

    // next state and divider control
    always_comb
    begin
        state_next        = state_reg;
        div_req.start     = 1'b0;
        div_req.short_run = 1'b0;
        div_dividend      = vel_dividend;
        div_divisor       = dt_reg;
        case (state_reg)
            eva_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = eva_pkg::ST_CALC;
                end
            end
            eva_pkg::ST_CALC:
            begin
                state_next = dt_zero ? eva_pkg::ST_RESULT : eva_pkg::ST_MUL;
            end
            eva_pkg::ST_MUL:
            begin
                div_req.start = 1'b1;
                state_next    = eva_pkg::ST_DIV_VEL;
            end
            eva_pkg::ST_DIV_VEL:
            begin
                if (div_stat.done)
                begin
                    state_next = eva_pkg::ST_UPD;
                end
            end
            eva_pkg::ST_UPD:
            begin
                state_next = eva_pkg::ST_AVG_GO;
            end
            eva_pkg::ST_AVG_GO:
            begin
                div_req.start     = 1'b1;
                div_req.short_run = 1'b1;
                div_dividend      = PW'(sum_mag);
                div_divisor       = VW'(HISTORY_DEPTH);
                state_next        = eva_pkg::ST_DIV_AVG;
            end
            eva_pkg::ST_DIV_AVG:
            begin
                if (div_stat.done)
                begin
                    state_next = eva_pkg::ST_RESULT;
                end
            end
            eva_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = eva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eva_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eva_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_reg     <= '0;
            rev_enc_reg <= 1'b0;
            rev_mot_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                eva_pkg::CFG_DIST_PER_TICK: dpt_reg     <= cfg_data;
                eva_pkg::CFG_REVERSE_ENC:   rev_enc_reg <= cfg_data[0];
                eva_pkg::CFG_REVERSE_MOTOR: rev_mot_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // state that persists between samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cnt_reg  <= '0;
            prev_time_reg <= '0;
            sum_reg       <= '0;
            last_avg_reg  <= '0;
            slot_reg      <= '0;
            valid_reg     <= '0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            if (state_reg == eva_pkg::ST_CALC && dt_zero)
            begin
                upd_reg <= 1'b0;
            end
            if (state_reg == eva_pkg::ST_UPD)
            begin
                upd_reg             <= 1'b1;
                prev_cnt_reg        <= cnt_reg;
                prev_time_reg       <= time_reg;
                sum_reg             <= sum_next;
                valid_reg[slot_reg] <= 1'b1;
                if (slot_reg == IDX_W'(HISTORY_DEPTH - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + IDX_W'(1);
                end
            end
            if (state_reg == eva_pkg::ST_DIV_AVG && div_stat.done)
            begin
                last_avg_reg <= avg_q;
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cnt_reg  <= in_count;
            time_reg <= s_axis_tdata[CW+TW-1:CW];
        end
        if (state_reg == eva_pkg::ST_CALC)
        begin
            dt_reg   <= dt;
            vneg_reg <= ticks[CW-1];
            tmag_reg <= ticks[CW-1] ? CW'(0) - ticks : ticks;
            k_reg    <= KW'(dpt_reg) * KW'(eva_pkg::SCALE);
        end
        if (state_reg == eva_pkg::ST_DIV_VEL && div_stat.done)
        begin
            v_reg <= v_sat;
        end
        if (state_reg == eva_pkg::ST_AVG_GO)
        begin
            avg_neg_reg <= sum_reg[SUM_W-1];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= last_avg_reg;
            out_user_reg <= upd_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    eva_ram #(
        .WIDTH (VW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (state_reg == eva_pkg::ST_UPD),
        .waddr (slot_reg),
        .wdata (v_reg),
        .re    (state_reg == eva_pkg::ST_CALC),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    eva_divider #(
        .DVD_W   (PW),
        .DVS_W   (VW),
        .SHORT_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient_w)
    );

endmodule

/* design/eva_checker.sv */
module eva_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [eva_pkg::VEL_W-1:0]      m_axis_tdata,
    input logic                           m_axis_tuser
);

    // result held while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed during stall");

    // nothing to send while in reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
    else $error("output valid during reset");

    // one sample at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

    // an idle output stays idle right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind encoder_velocity_averager eva_checker u_eva_checker (.*);

/* verif/tb_encoder_velocity_averager.sv */
`timescale 1ns / 1ps

module tb_encoder_velocity_averager;

    import eva_pkg::*;

    localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
    localparam int DIR_ROWS   = 29;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_AFTER = 500;
    localparam int HOLD_CYCLES = 600;

    // index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [VEL_W-1:0] avg;
        logic             upd;
    } velocity_result_t;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [CNT_W-1:0]      cnt;
        logic [TIME_W-1:0]     ts;
        logic                  typed;
        logic [VEL_W-1:0]      exp_avg;
        logic                  exp_upd;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [VEL_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    encoder_velocity_averager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [DPT_W-1:0]  m_dpt;
    logic              m_rev_enc;
    logic              m_rev_mot;
    logic [CNT_W-1:0]  m_prev_count;
    logic [TIME_W-1:0] m_prev_ts;
    longint            m_hist [HIST_DEPTH];
    int                m_slot;
    longint            m_sum;
    logic [VEL_W-1:0]  m_last_avg;

    velocity_result_t  pending_averages [$];
    velocity_result_t  want;
    step_row_t         directed_rows [DIR_ROWS];

    int err_count    = 0;
    int sent_count   = 0;
    int zero_dt_seen = 0;
    int checked      = 0;
    int reg_writes   = 0;
    int burst_left   = 0;
    logic [CNT_W-1:0]  gen_cnt;
    logic [TIME_W-1:0] gen_ts;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("tb_encoder_velocity_averager: FAIL");
        $finish;
    end

    task automatic predict_average(input logic [CNT_W-1:0] raw, input logic [TIME_W-1:0] ts,
                                   output logic [VEL_W-1:0] avg, output logic upd);
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  diff;
        logic [TIME_W-1:0] dt;
        longint            ticks;
        longint            prod;
        longint            vel;
        longint            mean;
        cnt = (m_rev_enc ^ m_rev_mot) ? (32'd0 - raw) : raw;
        dt = ts - m_prev_ts;
        if (dt == 0)
        begin
            avg = m_last_avg;
            upd = 1'b0;
        end
        else
        begin
            diff = cnt - m_prev_count;
            ticks = longint'(signed'(diff));
            prod = ticks * 64'sd1000 * longint'({48'd0, m_dpt});
            vel = prod / longint'({32'd0, dt});
            if (vel > 64'sd2147483647)
                vel = 64'sd2147483647;
            if (vel < -64'sd2147483648)
                vel = -64'sd2147483648;
            m_sum = m_sum + vel - m_hist[m_slot];
            m_hist[m_slot] = vel;
            m_slot = (m_slot + 1) % HIST_DEPTH;
            mean = m_sum / HIST_DEPTH;
            m_last_avg = mean[VEL_W-1:0];
            m_prev_count = cnt;
            m_prev_ts = ts;
            avg = m_last_avg;
            upd = 1'b1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_DIST_PER_TICK: m_dpt = data;
            CFG_REVERSE_ENC:   m_rev_enc = data[0];
            CFG_REVERSE_MOTOR: m_rev_mot = data[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // stop offering samples and let every outstanding result drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_sample(input logic [CNT_W-1:0] cnt, input logic [TIME_W-1:0] ts,
                               input logic typed, input logic [VEL_W-1:0] t_avg,
                               input logic t_upd);
        int gap;
        velocity_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ts, cnt};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_average(cnt, ts, res.avg, res.upd);
        if (!res.upd)
            zero_dt_seen++;
        if (typed)
        begin
            res.avg = t_avg;
            res.upd = t_upd;
        end
        pending_averages.push_back(res);
        sent_count++;
    endtask

    task automatic send_random_sample();
        int r;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] ts;
        r = $urandom_range(0, 99);
        if (r < 6)
            ts = gen_ts;
        else if (r < 10)
            ts = $urandom;
        else if (r < 13)
            ts = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else
            ts = gen_ts + $urandom_range(1, 60);
        r = $urandom_range(0, 99);
        if (r < 6)
            cnt = $urandom;
        else if (r < 20)
            cnt = gen_cnt + $urandom_range(0, 1 << 22) - (1 << 21);
        else
            cnt = gen_cnt + $urandom_range(0, 4000) - 2000;
        gen_cnt = cnt;
        gen_ts  = ts;
        send_sample(cnt, ts, 1'b0, '0, 1'b0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_averages.size() == 0)
            begin
                err_count++;
                $display("%0t: result with nothing outstanding: avg=%h updated=%b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_averages.pop_front();
                if (m_axis_tdata !== want.avg)
                begin
                    err_count++;
                    $display("%0t: average_velocity expected %h actual %h",
                             $time, want.avg, m_axis_tdata);
                end
                if (m_axis_tuser !== want.upd)
                begin
                    err_count++;
                    $display("%0t: updated expected %b actual %b",
                             $time, want.upd, m_axis_tuser);
                end
                checked++;
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off to back up the input
    initial
    begin : receiver
        int  mode;
        int  mode_left;
        int  cyc;
        int  hold_left;
        bit  held;
        mode = 0;
        mode_left = 0;
        cyc = 0;
        hold_left = 0;
        held = 0;
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!held && sent_count >= HOLD_AFTER)
            begin
                held = 1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((cyc % 7) < 4);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int wait_cycles;
        logic [CFG_DATA_W-1:0] dpt;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wen       <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;

        m_dpt = '0;
        m_rev_enc = 1'b0;
        m_rev_mot = 1'b0;
        m_prev_count = '0;
        m_prev_ts = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            m_hist[i] = 0;
        m_slot = 0;
        m_sum = 0;
        m_last_avg = '0;

        //                 wr  index              data      count         time_ms
        //                 typed expected avg  upd
        directed_rows = '{
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h1234_5678, 32'h0000_0000,
              1'b1, 32'h0000_0000, 1'b0},   // zero interval right after reset
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0007,
              1'b1, 32'h0000_0000, 1'b1},   // scale still zero
            '{1'b1, CFG_DIST_PER_TICK, 16'hFFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0008,
              1'b1, 32'hF000_0000, 1'b1},   // delta -2^31, saturates low
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0009,
              1'b1, 32'hE000_0000, 1'b1},   // delta wraps back to -2^31
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0009,
              1'b1, 32'hE000_0000, 1'b0},   // repeat mean
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h8000_0000, 32'h0000_0008,
              1'b0, 32'h0, 1'b0},           // longest interval
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_0064, 32'h0000_0003,
              1'b0, 32'h0, 1'b0},           // timestamp wraps
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h8000_0063, 32'h0000_0004,
              1'b0, 32'h0, 1'b0},           // saturates high
            '{1'b1, CFG_REVERSE_ENC, 16'h0001, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h8000_0000, 32'h0000_0005,
              1'b0, 32'h0, 1'b0},           // most negative count stays put
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_0010, 32'h0000_0006,
              1'b0, 32'h0, 1'b0},
            '{1'b1, CFG_REVERSE_MOTOR, 16'h0001, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_0014, 32'h0000_000A,
              1'b0, 32'h0, 1'b0},           // both flags cancel
            '{1'b1, CFG_UNUSED, 16'h0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_03FC, 32'h0000_000B,
              1'b0, 32'h0, 1'b0},
            '{1'b1, CFG_REVERSE_ENC, 16'h0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_03E8, 32'h0000_000C,
              1'b0, 32'h0, 1'b0},
            '{1'b1, CFG_DIST_PER_TICK, 16'h0001, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_07D0, 32'h0000_0014,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_05DC, 32'h0000_0019,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_05DC, 32'h0000_0019,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'hFFFF_EC78, 32'h0000_001E,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'hFFFF_F000, 32'h0000_001F,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_1000, 32'h0000_0028,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0000_1001, 32'h0000_0029,
              1'b0, 32'h0, 1'b0},
            '{1'b0, CFG_UNUSED, 16'h0000, 32'h0010_0000, 32'h0000_0411,
              1'b0, 32'h0, 1'b0},           // history has wrapped by now
            '{1'b0, CFG_UNUSED, 16'h0000, 32'hFFF0_0000, 32'h0000_0412,
              1'b0, 32'h0, 1'b0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (directed_rows[i].is_write)
            begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                send_sample(directed_rows[i].cnt, directed_rows[i].ts, directed_rows[i].typed,
                            directed_rows[i].exp_avg, directed_rows[i].exp_upd);
                gen_cnt = directed_rows[i].cnt;
                gen_ts  = directed_rows[i].ts;
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: dpt = 16'h0000;
                1: dpt = 16'hFFFF;
                2: dpt = 16'h0001;
                3: dpt = 16'h8000;
                4: dpt = CFG_DATA_W'($urandom_range(1, 255));
                7: dpt = 16'hFFFF;
                default: dpt = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_DIST_PER_TICK, dpt);
            write_reg(CFG_REVERSE_ENC, CFG_DATA_W'($urandom_range(0, 65535)));
            write_reg(CFG_REVERSE_MOTOR, CFG_DATA_W'($urandom_range(0, 65535)));
            if (p % 3 == 0)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_sample();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        wait_cycles = 120;
        repeat (wait_cycles) @(posedge clk);

        $display("Run: %0d samples (%0d with zero interval), %0d results checked,",
                 sent_count, zero_dt_seen, checked);
        $display("     %0d register writes, %0d random phases, one long output hold-off.",
                 reg_writes, PHASES);
        if (err_count == 0 && pending_averages.size() == 0)
            $display("tb_encoder_velocity_averager: PASS");
        else
            $display("tb_encoder_velocity_averager: FAIL");
        $finish;
    end

endmodule

/* files.f */
design/eva_pkg.sv
design/eva_ram.sv
design/eva_divider.sv
design/encoder_velocity_averager.sv
design/eva_checker.sv
verif/tb_encoder_velocity_averager.sv
